[hw/rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helper functions of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned MaxPages  = 65536;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned NumWords  = MaxPages / WordBits;
  localparam int unsigned WordAw    = $clog2(NumWords);
  localparam int unsigned PgW       = 17;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PgW-1:0]      MaxPagesVal = 17'd65536;
  localparam logic [WordBits-1:0] WordOnes    = '1;

  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_ALLOC_ONE = 3'd1,
    OP_FREE_ONE  = 3'd2,
    OP_ALLOC_RUN = 3'd3,
    OP_FREE_RUN  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOTAL_PAGES  = 2'd0,
    REG_LOW_RESERVED = 2'd1,
    REG_KERNEL_FIRST = 2'd2,
    REG_KERNEL_END   = 2'd3
  } cfg_reg_e;

  // Outcome of scanning one byte of the bitmap for a run of free pages.
  typedef struct packed {
    logic           found;
    logic [PgW-1:0] start;
    logic [PgW-1:0] run;
    logic [PgW-1:0] first;
  } scan_res_t;

  // Bits of the word starting at page base whose page lies in [lo, hi).
  function automatic logic [WordBits-1:0] range_mask(input logic [PgW-1:0] base,
                                                     input logic [PgW-1:0] lo,
                                                     input logic [PgW-1:0] hi);
    logic [PgW:0]          base_end;
    logic [PgW-1:0]        dl;
    logic [PgW-1:0]        dh;
    logic [WordBits-1:0]   lm;
    logic [WordBits-1:0]   hm;
    base_end = {1'b0, base} + (PgW+1)'(WordBits);
    dl = lo - base;
    dh = hi - base;
    if (lo <= base) begin
      lm = WordOnes;
    end else if ({1'b0, lo} >= base_end) begin
      lm = '0;
    end else begin
      lm = WordOnes << dl[4:0];
    end
    if (hi <= base) begin
      hm = '0;
    end else if ({1'b0, hi} >= base_end) begin
      hm = WordOnes;
    end else begin
      hm = ~(WordOnes << dh[4:0]);
    end
    return lm & hm;
  endfunction

  function automatic logic [5:0] popcount(input logic [WordBits-1:0] w);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + 6'(w[i]);
    end
    return n;
  endfunction

endpackage

[hw/rtl/bitmap_page_allocator.sv]
// Init writes each bitmap word once; a free reads and rewrites each touched word.
// An allocation scans each bitmap word with one read and four 8-bit run steps,
// then marks its run with a read and a write per word.
// One command is in flight at a time; the bitmap RAM port sets the pace.
// After reset a sweep fills the bitmap with ones; no command is
// taken during it, configuration writes are.
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a one-bit-per-page bitmap in RAM.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PgW-1:0]     cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [31:0]        address_i,
  input  logic [PgW-1:0]     page_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [27:0]        page_address_o,
  output logic [PgW-1:0]     pages_in_use_o,
  output logic [PgW-1:0]     free_pages_o,
  output logic [PgW-1:0]     managed_pages_o
);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_INIT    = 8'b0000_0100,
    S_SCAN_RD = 8'b0000_1000,
    S_SCAN    = 8'b0001_0000,
    S_MOD_RD  = 8'b0010_0000,
    S_MOD_WR  = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [WordAw:0]   wcnt_q, wcnt_d;
  logic [1:0]        sub_q, sub_d;
  logic [PgW-1:0]    run_q, run_d, first_q, first_d, count_q, count_d;
  logic [PgW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [PgW-1:0]    used_q, used_d, limit_q, limit_d;
  logic              alloc_q, alloc_d;
  status_e           status_q, status_d;
  logic [27:0]       res_addr_q, res_addr_d;
  logic [PgW-1:0]    total_q, low_res_q, kfirst_q, kend_q;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q;
  logic [27:0]       out_addr_q;
  logic [PgW-1:0]    out_used_q, out_free_q, out_managed_q;

  logic                ram_we, ram_re;
  logic [WordBits-1:0] ram_wdata, ram_rdata;
  logic [PgW-1:0]      word_base;
  logic [WordBits-1:0] init_free, cur_mask, cleared;
  logic [PgW-1:0]      hi_m1;
  scan_res_t           scan_res;
  logic                load_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= MaxPagesVal;
      low_res_q <= 17'd256;
      kfirst_q  <= '0;
      kend_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TOTAL_PAGES:  total_q   <= cfg_data_i;
        REG_LOW_RESERVED: low_res_q <= cfg_data_i;
        REG_KERNEL_FIRST: kfirst_q  <= cfg_data_i;
        REG_KERNEL_END:   kend_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign word_base = {wcnt_q[WordAw-1:0], 5'b0_0000} + '0;
  assign hi_m1     = hi_q - 1'b1;
  assign cur_mask  = range_mask(word_base, lo_q, hi_q);
  assign cleared   = ram_rdata & cur_mask;

  // Pages left free by init: above the reserved area, below the total, and
  // neither page 0 nor part of the kernel image.
  always_comb begin
    init_free = range_mask(word_base, low_res_q, limit_q)
              & ~range_mask(word_base, kfirst_q, kend_q);
    if (wcnt_q == '0) begin
      init_free[0] = 1'b0;
    end
  end

  bpa_ram #(
    .Width(WordBits),
    .Depth(NumWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (wcnt_q[WordAw-1:0]),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  bpa_scan u_scan (
    .bits_i     (ram_rdata[{sub_q, 3'b000} +: 8]),
    .page_base_i({1'b0, wcnt_q[WordAw-1:0], sub_q, 3'b000}),
    .run_i      (run_q),
    .first_i    (first_q),
    .count_i    (count_q),
    .res_o      (scan_res)
  );

  always_comb begin
    logic [PgW-1:0] cnt;
    logic [PgW:0]   fsum;
    state_d    = state_q;
    wcnt_d     = wcnt_q;
    sub_d      = sub_q;
    run_d      = run_q;
    first_d    = first_q;
    count_d    = count_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    used_d     = used_q;
    limit_d    = limit_q;
    alloc_d    = alloc_q;
    status_d   = status_q;
    res_addr_d = res_addr_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = WordOnes;
    load_out   = 1'b0;
    cnt        = page_count_i;
    fsum       = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q[WordAw-1:0] == WordAw'(NumWords - 1)) begin
          wcnt_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          status_d   = ST_DONE;
          res_addr_d = '0;
          wcnt_d     = '0;
          state_d    = S_RESP;
          priority if (opcode_i == OP_INIT) begin
            limit_d = (total_q > MaxPagesVal) ? MaxPagesVal : total_q;
            used_d  = limit_d;
            state_d = S_INIT;
          end else if (opcode_i == OP_ALLOC_ONE || opcode_i == OP_ALLOC_RUN) begin
            if (opcode_i == OP_ALLOC_ONE) begin
              cnt = 17'd1;
            end
            count_d = cnt;
            run_d   = '0;
            first_d = '0;
            sub_d   = '0;
            alloc_d = 1'b1;
            if (cnt == '0) begin
              status_d = ST_REJECTED;
            end else begin
              state_d = S_SCAN_RD;
            end
          end else if (opcode_i == OP_FREE_ONE || opcode_i == OP_FREE_RUN) begin
            if (opcode_i == OP_FREE_ONE) begin
              cnt = 17'd1;
            end
            alloc_d = 1'b0;
            fsum    = {1'b0, address_i[28:12]} + {1'b0, cnt};
            if (address_i[11:0] != '0 || {12'b0, address_i[31:12]} >= {15'b0, limit_q}
                || cnt == '0) begin
              status_d = ST_REJECTED;
            end else begin
              lo_d    = address_i[28:12];
              hi_d    = (fsum > {1'b0, limit_q}) ? limit_q : fsum[PgW-1:0];
              wcnt_d  = {1'b0, address_i[27:17]};
              state_d = S_MOD_RD;
            end
          end else begin
            status_d = ST_REJECTED;
          end
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = ~init_free;
        used_d    = used_q - {11'b0, popcount(init_free)};
        wcnt_d    = wcnt_q + 1'b1;
        if (wcnt_q[WordAw-1:0] == WordAw'(NumWords - 1)) begin
          state_d = S_RESP;
        end
      end
      S_SCAN_RD: begin
        // Pages at and above the limit always read as used, so stop there.
        if ({wcnt_q, 5'b0_0000} >= limit_q) begin
          status_d = ST_NO_SPACE;
          state_d  = S_RESP;
        end else begin
          ram_re  = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        run_d   = scan_res.run;
        first_d = scan_res.first;
        sub_d   = sub_q + 1'b1;
        if (scan_res.found) begin
          lo_d       = scan_res.start;
          hi_d       = scan_res.start + count_q;
          used_d     = used_q + count_q;
          res_addr_d = {scan_res.start[15:0], 12'b0};
          wcnt_d     = {1'b0, scan_res.start[15:5]};
          state_d    = S_MOD_RD;
        end else if (sub_q == 2'd3) begin
          wcnt_d  = wcnt_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_MOD_RD: begin
        ram_re  = 1'b1;
        state_d = S_MOD_WR;
      end
      S_MOD_WR: begin
        ram_we = 1'b1;
        if (alloc_q) begin
          ram_wdata = ram_rdata | cur_mask;
        end else begin
          ram_wdata = ram_rdata & ~cur_mask;
          used_d    = used_q - {11'b0, popcount(cleared)};
        end
        if (wcnt_q[WordAw-1:0] == hi_m1[15:5]) begin
          state_d = S_RESP;
        end else begin
          wcnt_d  = wcnt_q + 1'b1;
          state_d = S_MOD_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wcnt_q      <= '0;
      sub_q       <= '0;
      used_q      <= '0;
      limit_q     <= '0;
      alloc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      sub_q       <= sub_d;
      used_q      <= used_d;
      limit_q     <= limit_d;
      alloc_q     <= alloc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    first_q    <= first_d;
    count_q    <= count_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    status_q   <= status_d;
    res_addr_q <= res_addr_d;
    if (load_out) begin
      out_status_q  <= status_q;
      out_addr_q    <= res_addr_q;
      out_used_q    <= used_q;
      out_free_q    <= limit_q - used_q;
      out_managed_q <= limit_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign page_address_o  = out_addr_q;
  assign pages_in_use_o  = out_used_q;
  assign free_pages_o    = out_free_q;
  assign managed_pages_o = out_managed_q;

endmodule

[hw/rtl/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bpa_scan.sv]
// ----------------------------------------------------------------------------
// bpa_scan
// Run finder: walks eight bitmap bits and extends the current free run.
// ----------------------------------------------------------------------------
module bpa_scan import bpa_pkg::*; (
  input  logic [7:0]     bits_i,
  input  logic [PgW-1:0] page_base_i,
  input  logic [PgW-1:0] run_i,
  input  logic [PgW-1:0] first_i,
  input  logic [PgW-1:0] count_i,
  output scan_res_t      res_o
);

  always_comb begin
    scan_res_t r;
    r.found = 1'b0;
    r.start = '0;
    r.run   = run_i;
    r.first = first_i;
    for (int j = 0; j < 8; j++) begin
      if (!r.found) begin
        if (bits_i[j]) begin
          r.run = '0;
        end else begin
          if (r.run == '0) begin
            r.first = page_base_i + PgW'(j);
          end
          r.run = r.run + 1'b1;
          if (r.run == count_i) begin
            r.found = 1'b1;
            r.start = r.first;
          end
        end
      end
    end
    res_o = r;
  end

endmodule

[hw/rtl/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the bitmap page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker import bpa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [PgW-1:0]     cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [2:0]         opcode_i,
  input logic [31:0]        address_i,
  input logic [PgW-1:0]     page_count_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [27:0]        page_address_o,
  input logic [PgW-1:0]     pages_in_use_o,
  input logic [PgW-1:0]     free_pages_o,
  input logic [PgW-1:0]     managed_pages_o
);

  // A stalled result stays valid and keeps its page address.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(page_address_o))
    else $error("result changed while stalled");

  // Used and free pages of a valid result add up to the managed total.
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> PgW'(pages_in_use_o + free_pages_o) == managed_pages_o)
    else $error("page counts inconsistent");

  // A failed command carries a zero address.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> page_address_o == '0)
    else $error("address on failed command");

  // Allocated addresses are page aligned.
  a_addr_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> page_address_o[11:0] == '0)
    else $error("misaligned page address");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the bitmap page allocator. A queue of commands feeds a
// handshake driver with random gaps; a monitor with random stalls compares each
// result against a bit-accurate software copy of the bitmap, counters and
// configuration, updated at every accepted command.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int unsigned CycleLimit = 4000000;

  typedef struct {
    logic [2:0]     op;
    logic [31:0]    addr;
    logic [PgW-1:0] cnt;
  } page_cmd_t;

  typedef struct {
    logic [1:0]     status;
    logic [27:0]    page_addr;
    logic [PgW-1:0] used;
    logic [PgW-1:0] free_n;
    logic [PgW-1:0] managed;
  } page_outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [PgW-1:0]     cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         opcode_i = '0;
  logic [31:0]        address_i = '0;
  logic [PgW-1:0]     page_count_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [27:0]        page_address_o;
  logic [PgW-1:0]     pages_in_use_o;
  logic [PgW-1:0]     free_pages_o;
  logic [PgW-1:0]     managed_pages_o;

  bitmap_page_allocator dut (.*);

  always #6 clk_i = ~clk_i;

  // Software copy of the allocator.
  bit            page_used [MaxPages];
  int unsigned   used_cnt;
  int unsigned   page_lim;
  int unsigned   cfg_total = 65536;
  int unsigned   cfg_low = 256;
  int unsigned   cfg_kfirst = 0;
  int unsigned   cfg_kend = 0;

  page_cmd_t     pending_cmds[$];
  page_outcome_t expected_outcomes[$];
  int            error_cnt = 0;
  bit            long_hold_req = 1'b0;
  bit            quiet_phase = 1'b0;
  int unsigned   cycle_cnt = 0;

  function automatic void take_page(int unsigned p);
    if (p < page_lim && !page_used[p]) begin
      page_used[p] = 1'b1;
      used_cnt++;
    end
  endfunction

  function automatic void release_page(int unsigned p);
    if (p < page_lim && page_used[p]) begin
      page_used[p] = 1'b0;
      used_cnt--;
    end
  endfunction

  function automatic page_outcome_t apply_command(page_cmd_t c);
    page_outcome_t r;
    int unsigned   n;
    int unsigned   run;
    int unsigned   first;
    int unsigned   idx;
    bit            found;
    r.status = ST_DONE;
    r.page_addr = '0;
    case (c.op)
      OP_INIT: begin
        page_lim = (cfg_total > MaxPages) ? MaxPages : cfg_total;
        for (int p = 0; p < MaxPages; p++) page_used[p] = 1'b1;
        used_cnt = page_lim;
        for (int unsigned p = cfg_low; p < page_lim; p++) release_page(p);
        take_page(0);
        for (int unsigned p = cfg_kfirst; p < cfg_kend && p < page_lim; p++) take_page(p);
      end
      OP_ALLOC_ONE, OP_ALLOC_RUN: begin
        n = (c.op == OP_ALLOC_ONE) ? 1 : c.cnt;
        if (n == 0) begin
          r.status = ST_REJECTED;
        end else begin
          run = 0;
          first = 0;
          found = 1'b0;
          for (int unsigned p = 0; p < page_lim; p++) begin
            if (page_used[p]) begin
              run = 0;
            end else begin
              if (run == 0) first = p;
              run++;
              if (run == n) begin
                found = 1'b1;
                break;
              end
            end
          end
          if (found) begin
            for (int unsigned p = first; p < first + n; p++) take_page(p);
            r.page_addr = 28'(first << 12);
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
      end
      OP_FREE_ONE, OP_FREE_RUN: begin
        n = (c.op == OP_FREE_ONE) ? 1 : c.cnt;
        idx = c.addr >> 12;
        if (c.addr[11:0] != 0 || idx >= page_lim || n == 0) begin
          r.status = ST_REJECTED;
        end else begin
          for (int unsigned p = idx; p < idx + n && p < page_lim; p++) release_page(p);
        end
      end
      default: r.status = ST_REJECTED;
    endcase
    r.used = PgW'(used_cnt);
    r.free_n = PgW'(page_lim - used_cnt);
    r.managed = PgW'(page_lim);
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (quiet_phase || k < 65) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver.
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    page_cmd_t c;
    bit        next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        c.op = opcode_i;
        c.addr = address_i;
        c.cnt = page_count_i;
        expected_outcomes.push_back(apply_command(c));
        send_gap = gap_len();
      end
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        opcode_i <= c.op;
        address_i <= c.addr;
        page_count_i <= c.cnt;
        next_valid = 1'b1;
      end
      in_valid_i <= next_valid;
    end
  end

  // Monitor.
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    page_outcome_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with nothing expected: status %0d", status_o);
          error_cnt++;
        end else begin
          e = expected_outcomes.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            error_cnt++;
          end
          if (page_address_o !== e.page_addr) begin
            $error("page_address: expected %h, got %h", e.page_addr, page_address_o);
            error_cnt++;
          end
          if (pages_in_use_o !== e.used) begin
            $error("pages_in_use: expected %0d, got %0d", e.used, pages_in_use_o);
            error_cnt++;
          end
          if (free_pages_o !== e.free_n) begin
            $error("free_pages: expected %0d, got %0d", e.free_n, free_pages_o);
            error_cnt++;
          end
          if (managed_pages_o !== e.managed) begin
            $error("managed_pages: expected %0d, got %0d", e.managed, managed_pages_o);
            error_cnt++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (gap_len() == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("bitmap_page_allocator regression: fail");
      $finish;
    end
  end

  task automatic write_config(int unsigned tot, int unsigned low, int unsigned kf,
                              int unsigned ke);
    cfg_total = tot & 17'h1FFFF;
    cfg_low = low & 17'h1FFFF;
    cfg_kfirst = kf & 17'h1FFFF;
    cfg_kend = ke & 17'h1FFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_TOTAL_PAGES;
    cfg_data_i <= PgW'(tot);
    @(posedge clk_i);
    cfg_index_i <= REG_LOW_RESERVED;
    cfg_data_i <= PgW'(low);
    @(posedge clk_i);
    cfg_index_i <= REG_KERNEL_FIRST;
    cfg_data_i <= PgW'(kf);
    @(posedge clk_i);
    cfg_index_i <= REG_KERNEL_END;
    cfg_data_i <= PgW'(ke);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_cmd(logic [2:0] op, logic [31:0] addr, logic [PgW-1:0] cnt);
    page_cmd_t c;
    c.op = op;
    c.addr = addr;
    c.cnt = cnt;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid_i || expected_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random command, mostly well formed for the current page total.
  task automatic push_random(int unsigned lim);
    int unsigned k;
    int unsigned pg;
    k = $urandom_range(0, 99);
    pg = $urandom_range(0, lim + 2);
    if (k < 30) begin
      push_cmd(OP_ALLOC_ONE, $urandom, PgW'($urandom));
    end else if (k < 50) begin
      push_cmd(OP_ALLOC_RUN, $urandom, PgW'($urandom_range(1, 8)));
    end else if (k < 70) begin
      push_cmd(OP_FREE_ONE, pg << 12, PgW'($urandom));
    end else if (k < 83) begin
      push_cmd(OP_FREE_RUN, pg << 12, PgW'($urandom_range(1, 12)));
    end else if (k < 86) begin
      push_cmd(OP_INIT, $urandom, PgW'($urandom));
    end else if (k < 90) begin
      push_cmd(3'($urandom_range(5, 7)), $urandom, PgW'($urandom));
    end else begin
      push_cmd(3'($urandom_range(1, 4)), $urandom, PgW'($urandom));
    end
  endtask

  initial begin
    int unsigned tot;
    int unsigned lim;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Commands before any init, then the default configuration.
    push_cmd(OP_ALLOC_ONE, 32'h0, 17'h0);
    push_cmd(OP_FREE_ONE, 32'h0, 17'h1);
    push_cmd(OP_ALLOC_RUN, 32'h0, 17'h1);
    push_cmd(OP_FREE_RUN, 32'h0, 17'h1);
    push_cmd(3'd5, 32'hFFFFFFFF, 17'h1FFFF);
    push_cmd(3'd7, 32'h0, 17'h0);
    push_cmd(OP_INIT, 32'h0, 17'h0);
    push_cmd(OP_ALLOC_ONE, 32'h0, 17'h0);
    push_cmd(OP_ALLOC_RUN, 32'h0, 17'h4);
    push_cmd(OP_FREE_ONE, 32'h0010_0000, 17'h0);
    push_cmd(OP_FREE_ONE, 32'h0010_0000, 17'h0);
    push_cmd(OP_FREE_ONE, 32'h0010_0001, 17'h0);
    push_cmd(OP_FREE_ONE, 32'hFFFFF000, 17'h0);
    push_cmd(OP_FREE_RUN, 32'h0010_0000, 17'h0);
    push_cmd(OP_ALLOC_RUN, 32'h0, 17'h0);
    push_cmd(OP_FREE_RUN, 32'h0FFFF000, 17'h10000);
    push_cmd(OP_ALLOC_RUN, 32'h0, 17'h1FFFF);
    push_cmd(OP_FREE_RUN, 32'h0, 17'h1FFFF);
    push_cmd(OP_ALLOC_RUN, 32'h0, 17'h10000);
    push_cmd(OP_ALLOC_ONE, 32'h0, 17'h0);
    push_cmd(OP_FREE_ONE, 32'h1000_0000, 17'h0);
    wait_drained();

    // Clamped total and an empty kernel range with end below first.
    write_config(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 0);
    push_cmd(OP_INIT, 32'h0, 17'h0);
    push_cmd(OP_ALLOC_ONE, 32'h0, 17'h0);
    push_cmd(OP_FREE_RUN, 32'h0, 17'h10000);
    push_cmd(OP_ALLOC_ONE, 32'h0, 17'h0);
    push_cmd(OP_ALLOC_RUN, 32'h0, 17'h10000);
    wait_drained();

    write_config(0, 0, 0, 0);
    push_cmd(OP_INIT, 32'h0, 17'h0);
    push_cmd(OP_ALLOC_ONE, 32'h0, 17'h0);
    push_cmd(OP_FREE_ONE, 32'h0, 17'h0);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: tot = $urandom_range(1, 40);
        1: tot = $urandom_range(64, 600);
        2: tot = $urandom_range(600, 2000);
        default: tot = $urandom_range(30, 300);
      endcase
      write_config(tot, $urandom_range(0, tot + 2), $urandom_range(0, tot),
                   $urandom_range(0, tot + 4));
      lim = tot;
      quiet_phase = (ph == 5);
      if (ph == 3) long_hold_req = 1'b1;
      push_cmd(OP_INIT, $urandom, PgW'($urandom));
      for (int i = 0; i < 22; i++) push_random(lim);
      wait_drained();
    end
    quiet_phase = 1'b0;

    repeat (50) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("bitmap_page_allocator regression: pass");
    end else begin
      $display("bitmap_page_allocator regression: fail");
    end
    $finish;
  end

endmodule
